[rtl/whb_pkg.sv]
package whb_pkg;

	localparam int BIN_COUNT  = 1024;
	localparam int IDX_W      = $clog2(BIN_COUNT);
	localparam int ACC_BITS   = 48;
	localparam int USED_W     = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NEG   = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WMODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MINLEN = 1'd1;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] bin_index;
		logic signed [31:0] weight;
		logic               last_read;
	} item_t;

	typedef struct packed {
		logic        [1:0]          status;
		logic signed [ACC_BITS-1:0] bin_total;
		logic        [USED_W-1:0]   bins_used;
	} result_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} sts_t;

endpackage

[rtl/whb_ctrl.sv]
module whb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output whb_pkg::cmd_t cmd,
	input  whb_pkg::sts_t sts
);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy      = busy_q;
	assign cmd.clear = (state_q == S_CLEAR);
	assign cmd.load  = (state_q == S_IDLE) && start;
	assign cmd.exec  = (state_q == S_EXEC);

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> busy_q)
		else $error("busy low during the clearing pass");

	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC))
		else $error("accepted transaction did not enter execution");

	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_IDLE && !busy_q))
		else $error("execution lasted more than one cycle");

endmodule

[rtl/whb_dp.sv]
module whb_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  whb_pkg::cmd_t                      cmd,
	output whb_pkg::sts_t                      sts,
	input  whb_pkg::item_t                     item,
	output logic                               done,
	output whb_pkg::result_t                   result,
	input  logic                               cfg_we,
	input  logic [whb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [whb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int A = whb_pkg::ACC_BITS;
	localparam int I = whb_pkg::IDX_W;
	localparam int U = whb_pkg::USED_W;

	logic [A-1:0] mem [whb_pkg::BIN_COUNT];

	whb_pkg::item_t   item_q;
	whb_pkg::result_t res_q;
	logic             done_q;
	logic [A-1:0]     rd_q;
	logic [I-1:0]     clr_cnt_q;
	logic [I-1:0]     hi_q;
	logic             seen_q;
	logic             wmode_q;
	logic [U-1:0]     minlen_q;

	logic [1:0]       stat;
	logic [I-1:0]     idx;
	logic [A-1:0]     wext;
	logic [A:0]       sum;
	logic [A-1:0]     sat;
	logic [A-1:0]     wdata;
	logic             wr;
	logic [U-1:0]     hi_used;
	logic [U-1:0]     used;

	always_comb begin
		idx = item_q.bin_index[I-1:0];
		if (item_q.bin_index[31]) begin
			stat = whb_pkg::STAT_NEG;
		end else if (item_q.bin_index[30:0] >= 31'(whb_pkg::BIN_COUNT)) begin
			stat = whb_pkg::STAT_RANGE;
		end else begin
			stat = whb_pkg::STAT_OK;
		end

		if (wmode_q) begin
			wext = {{(A-32){item_q.weight[31]}}, item_q.weight};
		end else begin
			wext = A'(1);
		end
		sum = {rd_q[A-1], rd_q} + {wext[A-1], wext};
		if (sum[A] != sum[A-1]) begin
			sat = sum[A] ? {1'b1, {(A-1){1'b0}}} : {1'b0, {(A-1){1'b1}}};
		end else begin
			sat = sum[A-1:0];
		end

		wdata = (item_q.kind == whb_pkg::KIND_ADD) ? sat : '0;
		wr    = cmd.exec && (stat == whb_pkg::STAT_OK);

		hi_used = U'(hi_q) + U'(1);
		used    = (seen_q && hi_used > minlen_q) ? hi_used : minlen_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			rd_q   <= mem[item.bin_index[I-1:0]];
		end
		if (cmd.clear) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr) begin
			mem[idx] <= wdata;
		end
		res_q.status    <= stat;
		res_q.bin_total <= (stat == whb_pkg::STAT_OK) ? rd_q : '0;
		res_q.bins_used <= used;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			hi_q      <= '0;
			seen_q    <= 1'b0;
			wmode_q   <= 1'b0;
			minlen_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + I'(1);
			end
			done_q <= cmd.exec
				&& (item_q.kind == whb_pkg::KIND_READ || stat != whb_pkg::STAT_OK);
			if (cmd.exec) begin
				if (item_q.kind == whb_pkg::KIND_ADD) begin
					if (stat == whb_pkg::STAT_OK) begin
						if (!seen_q || idx > hi_q) begin
							hi_q <= idx;
						end
						seen_q <= 1'b1;
					end
				end else if (item_q.last_read) begin
					hi_q   <= '0;
					seen_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					whb_pkg::CFG_WMODE:  wmode_q  <= cfg_data[0];
					whb_pkg::CFG_MINLEN: minlen_q <= cfg_data[U-1:0];
					default: ;
				endcase
			end
		end
	end

	assign sts.clear_done = cmd.clear && (clr_cnt_q == I'(whb_pkg::BIN_COUNT - 1));
	assign done           = done_q;
	assign result         = res_q;

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.exec))
		else $error("result strobe without an executed transaction");

endmodule

[rtl/weighted_histogram_bincount.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------
// input    | start / busy           | item (kind, bin_index, weight, last_read)
// result   | done, one-cycle strobe | result (status, bin_total, bins_used)
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The bin memory read is registered when a transaction is accepted; the
// saturating add (or, for a read, the clear) and write-back follow in execution.
// A result appears on done for reads and rejected items only, in the cycle
// after execution; the next transaction may be accepted in that same cycle.
// After reset the bin memory is cleared one entry per cycle, with busy high
// until all 1024 entries are clear; configuration writes are taken throughout.
// The receiver cannot stall; cfg_ready is always high.
module weighted_histogram_bincount (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  whb_pkg::item_t                     item,
	output logic                               done,
	output whb_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [whb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [whb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	whb_pkg::cmd_t cmd;
	whb_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	whb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	whb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

[verif/whb_checker.sv]
module whb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  whb_pkg::item_t                 item,
	input  logic                           done,
	input  whb_pkg::result_t               result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [whb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [whb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ACC_MAX  = (longint'(1) <<< (whb_pkg::ACC_BITS - 1)) - 1;
	localparam longint ACC_MIN  = -ACC_MAX - 1;
	localparam int     USED_MAX = (1 << whb_pkg::USED_W) - 1;

	longint           bin_acc [whb_pkg::BIN_COUNT];
	int               top_bin;
	bit               seen;
	bit               weighted;
	int               min_len;
	whb_pkg::result_t expected_results [$];

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic bit histogram_step(input whb_pkg::item_t it,
			output whb_pkg::result_t r);
		logic [1:0] st;
		int         idx;
		int         used;
		longint     incr;
		longint     sum;
		st  = whb_pkg::STAT_OK;
		idx = 0;
		if (it.bin_index < 0) begin
			st = whb_pkg::STAT_NEG;
		end else if (it.bin_index >= whb_pkg::BIN_COUNT) begin
			st = whb_pkg::STAT_RANGE;
		end else begin
			idx = it.bin_index;
		end
		used = min_len;
		if (seen && top_bin + 1 > used) begin
			used = top_bin + 1;
		end
		if (used > USED_MAX) begin
			used = USED_MAX;
		end
		r.status    = st;
		r.bin_total = '0;
		r.bins_used = whb_pkg::USED_W'(used);
		if (it.kind == whb_pkg::KIND_ADD) begin
			if (st != whb_pkg::STAT_OK) begin
				return 1'b1;
			end
			incr = weighted ? longint'(it.weight) : longint'(1);
			sum  = bin_acc[idx] + incr;
			if (sum > ACC_MAX) begin
				sum = ACC_MAX;
			end else if (sum < ACC_MIN) begin
				sum = ACC_MIN;
			end
			bin_acc[idx] = sum;
			if (!seen || idx > top_bin) begin
				top_bin = idx;
			end
			seen = 1'b1;
			return 1'b0;
		end
		if (st == whb_pkg::STAT_OK) begin
			r.bin_total  = whb_pkg::ACC_BITS'(bin_acc[idx]);
			bin_acc[idx] = 0;
		end
		if (it.last_read) begin
			top_bin = 0;
			seen    = 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		whb_pkg::result_t want;
		whb_pkg::result_t forecast;
		if (!arst_n) begin
			for (int i = 0; i < whb_pkg::BIN_COUNT; i++) begin
				bin_acc[i] = 0;
			end
			top_bin  = 0;
			seen     = 1'b0;
			weighted = 1'b0;
			min_len  = 0;
			errors   = 0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result with no transaction pending", 64'(result), '0);
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status) begin
						flag_mismatch("status", 64'(result.status), 64'(want.status));
					end
					if (result.bin_total !== want.bin_total) begin
						flag_mismatch("bin_total", 64'(result.bin_total),
							64'(want.bin_total));
					end
					if (result.bins_used !== want.bins_used) begin
						flag_mismatch("bins_used", 64'(result.bins_used),
							64'(want.bins_used));
					end
				end
			end
			if (start && !busy) begin
				if (histogram_step(item, forecast)) begin
					expected_results.push_back(forecast);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					whb_pkg::CFG_WMODE: begin
						weighted = cfg_data[0];
					end
					whb_pkg::CFG_MINLEN: begin
						min_len = int'(cfg_data);
					end
					default: begin
					end
				endcase
			end
			pending <= expected_results.size();
		end
	end

endmodule

[verif/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 5000;
	localparam int PHASE_ITEMS  = 70;
	localparam int PHASE_COUNT  = 8;
	localparam int SAT_ADDS     = 16;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	whb_pkg::item_t                 item;
	logic                           done;
	whb_pkg::result_t               result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [whb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [whb_pkg::CFG_DATA_W-1:0] cfg_data;
	int                             errors;
	int                             pending;
	int                             quiet_cycles;
	bit                             gaps_on;

	weighted_histogram_bincount dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	whb_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic whb_pkg::item_t mk(input logic kind, input logic signed [31:0] idx,
			input logic signed [31:0] w, input logic last);
		whb_pkg::item_t it;
		it.kind      = kind;
		it.bin_index = idx;
		it.weight    = w;
		it.last_read = last;
		return it;
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0001_0000 * $urandom_range(0, 8);
			3: return -(32'h0001_0000 * $urandom_range(1, 8));
			default: return $urandom();
		endcase
	endfunction

	function automatic whb_pkg::item_t rand_item();
		whb_pkg::item_t it;
		int unsigned    pick;
		it.kind = ($urandom_range(0, 99) < 40) ? whb_pkg::KIND_READ : whb_pkg::KIND_ADD;
		pick    = $urandom_range(0, 99);
		if (pick < 50) begin
			it.bin_index = $urandom_range(0, 15);
		end else if (pick < 70) begin
			it.bin_index = $urandom_range(0, whb_pkg::BIN_COUNT - 1);
		end else if (pick < 76) begin
			it.bin_index = whb_pkg::BIN_COUNT - 1 - $urandom_range(0, 3);
		end else if (pick < 85) begin
			it.bin_index = 32'h8000_0000 | $urandom();
		end else if (pick < 93) begin
			it.bin_index = whb_pkg::BIN_COUNT + $urandom_range(0, 7);
		end else begin
			it.bin_index = $urandom();
		end
		it.weight    = rand_weight();
		it.last_read = ($urandom_range(0, 6) == 0);
		return it;
	endfunction

	task automatic push_item(input whb_pkg::item_t it);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [whb_pkg::CFG_IDX_W-1:0] idx,
			input logic [whb_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_config(input logic wmode, input int unsigned min_len);
		write_reg(whb_pkg::CFG_WMODE, whb_pkg::CFG_DATA_W'(wmode));
		write_reg(whb_pkg::CFG_MINLEN, whb_pkg::CFG_DATA_W'(min_len));
		cfg_valid <= 1'b0;
	endtask

	// Waits out every outstanding result with start low, then runs on idle clocks before returning.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (busy || pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic pump(input int idx, input logic [31:0] w, input int count);
		repeat (count) push_item(mk(whb_pkg::KIND_ADD, idx, w, 1'b0));
	endtask

	task automatic run_phase(input int count);
		int sent;
		int base;
		int adds;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 7) begin
				base = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12)
					: $urandom_range(0, whb_pkg::BIN_COUNT - 4);
				adds = $urandom_range(2, 8);
				repeat (adds) begin
					push_item(mk(whb_pkg::KIND_ADD, base + $urandom_range(0, 3),
						rand_weight(), 1'($urandom_range(0, 1))));
				end
				for (int k = 0; k < 4; k++) begin
					push_item(mk(whb_pkg::KIND_READ, base + k, $urandom(), k == 3));
				end
				sent += adds + 4;
			end else begin
				push_item(rand_item());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		gaps_on   = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		load_config(1'b0, 0);
		push_item(mk(whb_pkg::KIND_READ, 0, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 0, 5, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, whb_pkg::BIN_COUNT - 1, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, -1, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 32'h8000_0000, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, whb_pkg::BIN_COUNT, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 32'h7FFF_FFFF, 0, 1'b1));
		push_item(mk(whb_pkg::KIND_READ, whb_pkg::BIN_COUNT - 1, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_READ, -5, 0, 1'b1));
		push_item(mk(whb_pkg::KIND_READ, 0, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 5, 0, 1'b1));
		push_item(mk(whb_pkg::KIND_READ, 2000, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 9, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 9, 0, 1'b0));
		settle();

		// Bins keep their counts across a mode change.
		load_config(1'b1, whb_pkg::BIN_COUNT);
		push_item(mk(whb_pkg::KIND_ADD, 9, 32'h0001_0000, 1'b0));
		push_item(mk(whb_pkg::KIND_READ, 9, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 7, 32'h7FFF_FFFF, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 7, 32'h8000_0000, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 7, -1, 1'b0));
		push_item(mk(whb_pkg::KIND_READ, 7, 0, 1'b1));
		pump(100, 32'h7FFF_FFFF, SAT_ADDS);
		push_item(mk(whb_pkg::KIND_READ, 100, 0, 1'b0));
		pump(100, 32'h8000_0000, SAT_ADDS);
		push_item(mk(whb_pkg::KIND_ADD, 100, 5, 1'b0));
		push_item(mk(whb_pkg::KIND_READ, 100, 0, 1'b1));
		settle();

		load_config(1'b0, (1 << whb_pkg::USED_W) - 1);
		push_item(mk(whb_pkg::KIND_READ, 3, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_ADD, 3, 0, 1'b0));
		push_item(mk(whb_pkg::KIND_READ, 3, 0, 1'b1));
		settle();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: load_config(1'b0, 0);
				1: load_config(1'b1, whb_pkg::BIN_COUNT);
				2: load_config(1'b0, 1);
				3: load_config(1'b1, 0);
				4: load_config(1'b0, whb_pkg::BIN_COUNT);
				default: load_config(1'($urandom_range(0, 1)),
					$urandom_range(0, whb_pkg::BIN_COUNT));
			endcase
			gaps_on = (p != PHASE_COUNT - 1);
			run_phase(PHASE_ITEMS);
			settle();
		end

		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
